// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the date adder rtl
// no dependencies; compiled out when ASSERT_OFF is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/gda_pkg.sv =====
// shared types, constants and calendar helpers for the date adder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package gda_pkg;

    // unit codes
    localparam logic [2:0] OP_DAY        = 3'd0;
    localparam logic [2:0] OP_WEEK       = 3'd1;
    localparam logic [2:0] OP_MONTH      = 3'd2;
    localparam logic [2:0] OP_YEAR       = 3'd3;
    localparam logic [2:0] OP_DECADE     = 3'd4;
    localparam logic [2:0] OP_CENTURY    = 3'd5;
    localparam logic [2:0] OP_MILLENNIUM = 3'd6;

    // calendar constants
    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;
    localparam logic [14:0] YEAR_MAX  = 15'd32767;
    localparam logic [4:0]  FEB_LEAP  = 5'd29;

    // reciprocal of 25 scaled by 2^20, exact quotient for 15-bit years
    localparam logic [15:0] RECIP25 = 16'd41944;
    localparam logic [4:0]  DIV25   = 5'd25;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // payload of one input transaction
    typedef struct packed {
        logic [2:0]  operation;
        logic [4:0]  start_day;
        logic [3:0]  start_month;
        logic [14:0] start_year;
        logic [14:0] step_count;
    } in_t;

    // payload of one result transaction
    typedef struct packed {
        logic [4:0]  end_day;
        logic [3:0]  end_month;
        logic [14:0] end_year;
        logic        overflow;
        logic        bad_month;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mult;
        logic setup;
        logic step;
        logic store;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_run;
        logic run_done;
    } status_t;

    // length of month m (1..12) given the leap flag of its year
    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [3:0] idx;
        idx = m - 4'd1;
        if (m == MONTH_FEB && leap)
            return FEB_LEAP;
        else if (m >= MONTH_JAN && m <= MONTH_DEC)
            return MONTH_LEN[idx];
        else
            return MONTH_LEN[0];
    endfunction

    // units per count for the multiply stage
    function automatic logic [9:0] unit_scale(input logic [2:0] op);
        case (op)
            OP_WEEK:       return 10'd7;
            OP_DECADE:     return 10'd10;
            OP_CENTURY:    return 10'd100;
            OP_MILLENNIUM: return 10'd1000;
            default:       return 10'd1;
        endcase
    endfunction

endpackage

// ===== rtl/core/gda_ctrl.sv =====
// controller state machine for the date adder
// depends on gda_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gda_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  gda_pkg::status_t  status,
    output gda_pkg::cmd_t     cmd
);
    import gda_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MULT   = 3'd1;
    localparam logic [2:0] S_SETUP  = 3'd2;
    localparam logic [2:0] S_RUN    = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    // input side is open only between transactions
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MULT;
                end
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = status.need_run ? S_RUN : S_FINISH;
            end
            S_RUN:
            begin
                cmd.step = 1'b1;
                if (status.run_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.store  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid: set on store, cleared once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.store)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sequencing checks
    `ASSERT_NEXT(a_accept_to_mult, clk, rst_n, accept, state_reg == S_MULT)
    `ASSERT_NEXT(a_setup_skip_run, clk, rst_n, state_reg == S_SETUP && !status.need_run,
                 state_reg == S_FINISH)
    `ASSERT_NEXT(a_finish_delivers, clk, rst_n, state_reg == S_FINISH && out_free,
                 out_valid_reg && state_reg == S_IDLE)

endmodule

// ===== rtl/core/gda_datapath.sv =====
// datapath for the date adder: operand registers, multiply stage,
// day and month stepping, year saturation and the result register; uses gda_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gda_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  gda_pkg::in_t      in_data,
    input  gda_pkg::cmd_t     cmd,
    output gda_pkg::status_t  status,
    output gda_pkg::out_t     out_data
);
    import gda_pkg::*;

    logic [2:0]  op_reg,    op_next;
    logic [4:0]  d_reg,     d_next;
    logic [3:0]  m_reg,     m_next;
    logic [14:0] y_reg,     y_next;
    logic [14:0] n_reg,     n_next;
    logic [17:0] left_reg,  left_next;
    logic [24:0] prod_reg,  prod_next;
    logic [10:0] q_reg,     q_next;
    logic [4:0]  r25_reg,   r25_next;
    logic        ovf_reg,   ovf_next;
    logic        bad_reg,   bad_next;
    out_t        out_reg;

    logic        month_bad;
    logic        day_mode;
    logic        leap;
    logic [3:0]  m_inc;
    logic [4:0]  dim_cur;
    logic [4:0]  dim_new;
    logic [4:0]  adv;
    logic [4:0]  r25_inc;
    logic [30:0] qprod;
    logic [14:0] qx25;
    logic [14:0] rem;
    logic [25:0] ysum;
    logic        at_year_end;

    // decode of the held operands
    assign month_bad = (m_reg < MONTH_JAN) || (m_reg > MONTH_DEC);
    assign day_mode  = (op_reg == OP_DAY) || (op_reg == OP_WEEK);

    // leap rule from low year bits and the tracked year mod 25
    assign leap = (y_reg[1:0] == 2'd0) && ((r25_reg != 5'd0) || (y_reg[3:0] == 4'd0));

    // month lengths and next month
    assign m_inc   = (m_reg == MONTH_DEC) ? MONTH_JAN : m_reg + 4'd1;
    assign dim_cur = days_in(m_reg, leap);
    assign dim_new = days_in(m_inc, leap);
    assign adv     = dim_cur - d_reg;
    assign r25_inc = (r25_reg == DIV25 - 5'd1) ? 5'd0 : r25_reg + 5'd1;

    // year mod 25 by reciprocal multiply, remainder in the next cycle
    assign qprod = 31'(y_reg) * 31'(RECIP25);
    assign qx25  = 15'(q_reg) * 15'(DIV25);
    assign rem   = y_reg - qx25;
    assign ysum  = 26'(y_reg) + 26'(prod_reg);

    // a step that would carry into the year after the last one
    assign at_year_end = (m_reg == MONTH_DEC) && (y_reg == YEAR_MAX) &&
                         (!day_mode || (d_reg >= dim_cur));

    assign status.need_run = !month_bad && (op_reg <= OP_MONTH);
    assign status.run_done = (left_reg == 18'd0) || at_year_end;

    // register updates by command
    always_comb
    begin
        op_next   = op_reg;
        d_next    = d_reg;
        m_next    = m_reg;
        y_next    = y_reg;
        n_next    = n_reg;
        left_next = left_reg;
        prod_next = prod_reg;
        q_next    = q_reg;
        r25_next  = r25_reg;
        ovf_next  = ovf_reg;
        bad_next  = bad_reg;

        if (cmd.load)
        begin
            op_next  = in_data.operation;
            d_next   = in_data.start_day;
            m_next   = in_data.start_month;
            y_next   = in_data.start_year;
            n_next   = in_data.step_count;
            ovf_next = 1'b0;
            bad_next = 1'b0;
        end

        if (cmd.mult)
        begin
            prod_next = 25'(n_reg) * 25'(unit_scale(op_reg));
            q_next    = qprod[30:20];
        end

        if (cmd.setup)
        begin
            r25_next  = rem[4:0];
            left_next = prod_reg[17:0];
            if (month_bad)
                bad_next = 1'b1;
            else if (op_reg >= OP_YEAR && op_reg <= OP_MILLENNIUM)
            begin
                if (ysum > 26'(YEAR_MAX))
                begin
                    y_next   = YEAR_MAX;
                    ovf_next = 1'b1;
                end
                else
                    y_next = ysum[14:0];
            end
        end

        if (cmd.step && left_reg != 18'd0)
        begin
            if (at_year_end)
                ovf_next = 1'b1;
            else if (day_mode)
            begin
                if (d_reg >= dim_cur)
                begin
                    // roll into the next month
                    m_next    = m_inc;
                    d_next    = 5'd1;
                    left_next = left_reg - 18'd1;
                    if (m_reg == MONTH_DEC)
                    begin
                        y_next   = y_reg + 15'd1;
                        r25_next = r25_inc;
                    end
                end
                else if (18'(adv) > left_reg)
                begin
                    // remaining days end inside this month
                    d_next    = d_reg + left_reg[4:0];
                    left_next = 18'd0;
                end
                else
                begin
                    // jump to the last day of this month
                    d_next    = d_reg + adv;
                    left_next = left_reg - 18'(adv);
                end
            end
            else
            begin
                // one month forward, day clamped to the new length
                m_next    = m_inc;
                left_next = left_reg - 18'd1;
                if (d_reg > dim_new)
                    d_next = dim_new;
                if (m_reg == MONTH_DEC)
                begin
                    y_next   = y_reg + 15'd1;
                    r25_next = r25_inc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        d_reg    <= d_next;
        m_reg    <= m_next;
        y_reg    <= y_next;
        n_reg    <= n_next;
        left_reg <= left_next;
        prod_reg <= prod_next;
        q_reg    <= q_next;
        r25_reg  <= r25_next;
        ovf_reg  <= ovf_next;
        bad_reg  <= bad_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            out_reg.end_day   <= d_reg;
            out_reg.end_month <= m_reg;
            out_reg.end_year  <= y_reg;
            out_reg.overflow  <= ovf_reg;
            out_reg.bad_month <= bad_reg;
        end
    end

    assign out_data = out_reg;

    // stepping only runs on valid months, day-based or month units, reduced year
    `ASSERT_ALWAYS(a_step_month_ok, clk, rst_n, !cmd.step || !month_bad)
    `ASSERT_ALWAYS(a_step_unit_ok, clk, rst_n, !cmd.step || op_reg <= OP_MONTH)
    `ASSERT_ALWAYS(a_step_rem_ok, clk, rst_n, !cmd.step || r25_reg < DIV25)

endmodule

// ===== rtl/core/gregorian_date_adder_top.sv =====
// date adder: one transaction in (date, unit, count), one result out per transaction
// an accepted input passes the multiply and setup states to finish, where the result is stored
// once the output is free; year, decade, century, millennium and unknown units and bad months
// skip the stepping loop, which day, week and month units run between setup and finish
// a new transaction is taken only when idle; input reopens after the result is stored
// reset (rst_n low, asynchronous) returns the controller to idle with no result pending
`timescale 1ns / 1ps

module gregorian_date_adder_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  gda_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output gda_pkg::out_t  out_data
);
    import gda_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencing
    gda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and result register
    gda_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for gregorian_date_adder_top: directed and random dates
// depends on gda_pkg (payload types, unit codes, calendar limits) and the top level rtl
`timescale 1ns / 1ps

module tb_top;
    import gda_pkg::*;

    localparam logic [2:0]  OP_UNUSED      = 3'd7;
    localparam int unsigned RANDOM_ITEMS   = 2000;
    localparam int unsigned CYCLE_LIMIT    = 4000000;
    localparam int unsigned SETTLE_CYCLES  = 40;
    localparam int unsigned MODE_SPAN      = 128;
    localparam int unsigned DAYS_PER_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    in_t  in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;

    in_t  pending_requests [$];
    out_t expected_dates [$];

    int unsigned total_requests  = 0;
    int unsigned accepted_count  = 0;
    int unsigned checked_count   = 0;
    int unsigned overflow_count  = 0;
    int unsigned bad_month_count = 0;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;
    int unsigned feed_gap        = 0;
    int unsigned feed_mode       = 0;
    int unsigned stall_left      = 0;
    int unsigned drain_mode      = 0;

    gregorian_date_adder_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // gregorian leap rule
    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // length of month m (1..12) in year y
    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        if (m == MONTH_FEB && is_leap_year(y))
            return 29;
        return DAYS_PER_MONTH[m - 1];
    endfunction

    // expected result of advancing a date by a count of units
    function automatic out_t advance_date(input in_t req);
        int unsigned day;
        int unsigned mon;
        int unsigned yr;
        int unsigned left;
        int unsigned span;
        int unsigned adv;
        int unsigned scale;
        longint      total;
        logic        ovf;
        logic        bad;
        out_t        res;
        day = req.start_day;
        mon = req.start_month;
        yr  = req.start_year;
        ovf = 1'b0;
        bad = 1'b0;
        if (mon < MONTH_JAN || mon > MONTH_DEC)
            bad = 1'b1;
        else
        begin
            case (req.operation)
                OP_DAY, OP_WEEK:
                begin
                    // walk whole months at a time, one day across each month end
                    left = (req.operation == OP_WEEK) ? req.step_count * 7 : req.step_count;
                    while (left > 0)
                    begin
                        span = month_length(mon, yr);
                        if (day >= span)
                        begin
                            if (mon == MONTH_DEC)
                            begin
                                if (yr >= YEAR_MAX)
                                begin
                                    ovf = 1'b1;
                                    break;
                                end
                                mon = MONTH_JAN;
                                yr++;
                            end
                            else
                                mon++;
                            day = 1;
                            left--;
                        end
                        else
                        begin
                            adv = span - day;
                            if (adv > left)
                                adv = left;
                            day  += adv;
                            left -= adv;
                        end
                    end
                end
                OP_MONTH:
                begin
                    // one month per count, day clamped to the new month
                    for (int unsigned i = 0; i < req.step_count; i++)
                    begin
                        if (mon == MONTH_DEC)
                        begin
                            if (yr >= YEAR_MAX)
                            begin
                                ovf = 1'b1;
                                break;
                            end
                            mon = MONTH_JAN;
                            yr++;
                        end
                        else
                            mon++;
                        span = month_length(mon, yr);
                        if (day > span)
                            day = span;
                    end
                end
                OP_YEAR, OP_DECADE, OP_CENTURY, OP_MILLENNIUM:
                begin
                    case (req.operation)
                        OP_DECADE:     scale = 10;
                        OP_CENTURY:    scale = 100;
                        OP_MILLENNIUM: scale = 1000;
                        default:       scale = 1;
                    endcase
                    total = longint'(yr) + longint'(req.step_count) * scale;
                    if (total > YEAR_MAX)
                    begin
                        total = YEAR_MAX;
                        ovf   = 1'b1;
                    end
                    yr = 32'(total);
                end
                default: ;
            endcase
        end
        res.end_day   = 5'(day);
        res.end_month = 4'(mon);
        res.end_year  = 15'(yr);
        res.overflow  = ovf;
        res.bad_month = bad;
        return res;
    endfunction

    // idle length: mode 0 never idles, mode 1 short gaps, others include long ones
    function automatic int unsigned pick_pause(input int unsigned mode);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return (roll < 70) ? 0 : $urandom_range(1, 3);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic void queue_request(input logic [2:0] op, input int unsigned d,
                                          input int unsigned m, input int unsigned y,
                                          input int unsigned n);
        in_t req;
        req.operation   = op;
        req.start_day   = 5'(d);
        req.start_month = 4'(m);
        req.start_year  = 15'(y);
        req.step_count  = 15'(n);
        pending_requests.push_back(req);
    endfunction

    // random date request, mostly well formed, with weighted years and counts
    function automatic in_t random_request();
        in_t         req;
        int unsigned roll;
        int unsigned yr;
        int unsigned mon;
        int unsigned len;
        req.operation = 3'($urandom_range(0, 7));

        // years: anywhere, around century boundaries, near the top, or modern
        roll = $urandom_range(0, 99);
        if (roll < 40)
            yr = $urandom_range(0, YEAR_MAX);
        else if (roll < 60)
            yr = $urandom_range(0, 327) * 100 + $urandom_range(0, 4);
        else if (roll < 75)
            yr = YEAR_MAX - $urandom_range(0, 40);
        else
            yr = $urandom_range(1580, 2100);
        req.start_year = 15'(yr);

        // well formed date, often at a month end; otherwise raw noise
        if ($urandom_range(0, 99) < 85)
        begin
            mon = $urandom_range(1, 12);
            len = month_length(mon, yr);
            req.start_month = 4'(mon);
            if ($urandom_range(0, 99) < 30)
                req.start_day = 5'(len - $urandom_range(0, 1));
            else
                req.start_day = 5'($urandom_range(1, len));
        end
        else
        begin
            req.start_month = 4'($urandom_range(0, 15));
            req.start_day   = 5'($urandom_range(0, 31));
        end

        // stepping units mostly take small counts, a rare one the full range
        roll = $urandom_range(0, 99);
        case (req.operation)
            OP_DAY:
                req.step_count = (roll < 1)  ? 15'($urandom_range(0, 32767)) :
                                 (roll < 40) ? 15'($urandom_range(0, 31)) :
                                 (roll < 80) ? 15'($urandom_range(0, 400)) :
                                               15'($urandom_range(0, 3000));
            OP_WEEK:
                req.step_count = (roll < 1)  ? 15'($urandom_range(0, 32767)) :
                                 (roll < 50) ? 15'($urandom_range(0, 8)) :
                                               15'($urandom_range(0, 500));
            OP_MONTH:
                req.step_count = (roll < 1)  ? 15'($urandom_range(0, 32767)) :
                                 (roll < 60) ? 15'($urandom_range(0, 24)) :
                                               15'($urandom_range(0, 300));
            default:
                req.step_count = (roll < 50) ? 15'($urandom_range(0, 32767)) :
                                               15'($urandom_range(0, 50));
        endcase
        return req;
    endfunction

    // driver: presents queued requests, holds each until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            feed_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_dates.push_back(advance_date(in_data));
                accepted_count <= accepted_count + 1;
                if ((accepted_count + 1) % MODE_SPAN == 0)
                    feed_mode <= $urandom_range(0, 3);
            end
            if (!in_valid || !in_stall)
            begin
                if (feed_gap > 0)
                begin
                    in_valid <= 1'b0;
                    feed_gap <= feed_gap - 1;
                end
                else if (pending_requests.size() > 0)
                begin
                    in_data  <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                    feed_gap <= pick_pause(feed_mode);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: random back-pressure and field-by-field comparison
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_dates.size() == 0)
                begin
                    $error("result transaction with nothing expected: %p", out_data);
                    error_count++;
                end
                else
                begin
                    out_t want;
                    want = expected_dates.pop_front();
                    if (out_data.end_day !== want.end_day)
                    begin
                        $error("end_day: expected %0d, got %0d", want.end_day, out_data.end_day);
                        error_count++;
                    end
                    if (out_data.end_month !== want.end_month)
                    begin
                        $error("end_month: expected %0d, got %0d",
                               want.end_month, out_data.end_month);
                        error_count++;
                    end
                    if (out_data.end_year !== want.end_year)
                    begin
                        $error("end_year: expected %0d, got %0d",
                               want.end_year, out_data.end_year);
                        error_count++;
                    end
                    if (out_data.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b",
                               want.overflow, out_data.overflow);
                        error_count++;
                    end
                    if (out_data.bad_month !== want.bad_month)
                    begin
                        $error("bad_month: expected %0b, got %0b",
                               want.bad_month, out_data.bad_month);
                        error_count++;
                    end
                end
                checked_count++;
                if (out_data.overflow === 1'b1)
                    overflow_count++;
                if (out_data.bad_month === 1'b1)
                    bad_month_count++;
                if (checked_count % MODE_SPAN == 0)
                    drain_mode <= $urandom_range(0, 3);
            end
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= pick_pause(drain_mode);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        // calendar edges: year end, leap rules, days past month end, day zero
        queue_request(OP_DAY, 31, 12, 1999, 1);
        queue_request(OP_DAY, 28, 2, 2024, 1);
        queue_request(OP_DAY, 28, 2, 1900, 1);
        queue_request(OP_DAY, 28, 2, 2000, 1);
        queue_request(OP_DAY, 30, 2, 2023, 1);
        queue_request(OP_DAY, 31, 4, 2021, 1);
        queue_request(OP_DAY, 0, 5, 2020, 1);
        // running off the top year and the largest counts
        queue_request(OP_DAY, 31, 12, YEAR_MAX, 1);
        queue_request(OP_WEEK, 25, 12, YEAR_MAX, 1);
        queue_request(OP_WEEK, 1, 1, 0, 32767);
        queue_request(OP_DAY, 1, 1, 0, 32767);
        // month steps: clamping, day zero kept, overflow
        queue_request(OP_MONTH, 31, 1, 2023, 1);
        queue_request(OP_MONTH, 31, 1, 2024, 13);
        queue_request(OP_MONTH, 0, 3, 2020, 5);
        queue_request(OP_MONTH, 15, 6, YEAR_MAX, 12);
        queue_request(OP_MONTH, 1, 1, 0, 32767);
        // year units: feb 29 kept, saturation, zero count
        queue_request(OP_YEAR, 29, 2, 2024, 1);
        queue_request(OP_DECADE, 1, 1, 32760, 1);
        queue_request(OP_CENTURY, 15, 7, 0, 327);
        queue_request(OP_MILLENNIUM, 31, 12, YEAR_MAX, 32767);
        queue_request(OP_MILLENNIUM, 1, 1, 0, 0);
        // unknown unit and out-of-range months
        queue_request(OP_UNUSED, 17, 8, 1234, 99);
        queue_request(OP_DAY, 10, 0, 2000, 5);
        queue_request(OP_MONTH, 31, 13, 2000, 5);
        queue_request(OP_YEAR, 31, 15, YEAR_MAX, 32767);
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
            pending_requests.push_back(random_request());
        total_requests = pending_requests.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_count < total_requests || expected_dates.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("%0d date requests over all units, leap boundaries and stalls on both sides;",
                 accepted_count);
        $display("%0d results checked, %0d saturated at the top year, %0d with a bad month",
                 checked_count, overflow_count, bad_month_count);
        if (error_count == 0 && expected_dates.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
